[hw/rtl/padded_glyph_blit_macros.svh]
// ----------------------------------------------------------------------------
// padded_glyph_blit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PADDED_GLYPH_BLIT_MACROS_SVH
`define PADDED_GLYPH_BLIT_MACROS_SVH

// same-cycle implication
`define PGB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pgb: same-cycle check failed");

// next-cycle implication
`define PGB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pgb: next-cycle check failed");

`endif

[hw/rtl/pgb_pkg.sv]
// ----------------------------------------------------------------------------
// pgb_pkg
// Constants, types and helper functions shared by the padded glyph blitter.
// ----------------------------------------------------------------------------
package pgb_pkg;

    localparam int MAX_ATLAS_SIDE  = 4096;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int ADDR_W     = 27;
    localparam int DATA_W     = 64;
    localparam int CNT_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int POS_W      = 12;
    localparam int AW_W       = 13;
    localparam int BPP_W      = 4;
    localparam int MODE_W     = 2;
    localparam int STRIDE_W   = AW_W + BPP_W;
    localparam int COLOFF_W   = CNT_W + BPP_W - 1;
    localparam int PROD_W     = 26;
    localparam int SIDE_CMP_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int NPOS       = 8;
    localparam int PIDX_W     = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING_MODE = 2'd2;

    // padding modes
    localparam logic [MODE_W-1:0] PAD_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] PAD_ZERO   = 2'd1;
    localparam logic [MODE_W-1:0] PAD_DILATE = 2'd2;

    // border positions, in emission order
    localparam logic [PIDX_W-1:0] POS_UL = 3'd0;
    localparam logic [PIDX_W-1:0] POS_U  = 3'd1;
    localparam logic [PIDX_W-1:0] POS_UR = 3'd2;
    localparam logic [PIDX_W-1:0] POS_L  = 3'd3;
    localparam logic [PIDX_W-1:0] POS_R  = 3'd4;
    localparam logic [PIDX_W-1:0] POS_DL = 3'd5;
    localparam logic [PIDX_W-1:0] POS_D  = 3'd6;
    localparam logic [PIDX_W-1:0] POS_DR = 3'd7;

    typedef struct packed {
        logic [AW_W-1:0]     atlas_width;
        logic [BPP_W-1:0]    bpp;        // clamped to 1..MAX_PIXEL_BYTES
        logic [STRIDE_W-1:0] stride;     // atlas_width * bpp
        logic                pad;
        logic                dilate;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] own;
        logic [DATA_W-1:0] pix;
        logic [NPOS-1:0]   need;
        logic [NPOS-1:0]   outside;
        logic              dilate;
    } t_job;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) r = SIZE_W'(1);
        else if (s > SIZE_W'(4096)) r = SIZE_W'(4096);
        return r;
    endfunction

    function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] b);
        logic [BPP_W-1:0] r;
        r = b;
        if (b == '0) r = BPP_W'(1);
        else if (b > BPP_W'(MAX_PIXEL_BYTES)) r = BPP_W'(MAX_PIXEL_BYTES);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pix_mask(input logic [BPP_W-1:0] b);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_W / 8; i++) begin
            if (BPP_W'(i) < b) m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic [PIDX_W-1:0] lowest_pos(input logic [NPOS-1:0] v);
        logic [PIDX_W-1:0] p;
        p = '0;
        for (int i = NPOS - 1; i >= 0; i--) begin
            if (v[i]) p = PIDX_W'(i);
        end
        return p;
    endfunction

endpackage

[hw/rtl/pgb_in_if.sv]
// ----------------------------------------------------------------------------
// pgb_in_if
// Pixel request channel: valid/ready handshake with the glyph pixel payload.
// ----------------------------------------------------------------------------
interface pgb_in_if import pgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              glyph_start;
    logic [POS_W-1:0]  slot_x;
    logic [POS_W-1:0]  slot_y;
    logic [SIZE_W-1:0] slot_width;
    logic [SIZE_W-1:0] slot_height;
    logic [DATA_W-1:0] pixel_value;

    modport source (output valid, glyph_start, slot_x, slot_y, slot_width, slot_height,
                    pixel_value, input ready);
    modport sink   (input valid, glyph_start, slot_x, slot_y, slot_width, slot_height,
                    pixel_value, output ready);
endinterface

[hw/rtl/pgb_out_if.sv]
// ----------------------------------------------------------------------------
// pgb_out_if
// Atlas write request channel: valid/ready handshake with address and data.
// ----------------------------------------------------------------------------
interface pgb_out_if import pgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              outside;
    logic              run_end;

    modport source (output valid, write_address, write_data, outside, run_end,
                    input ready);
    modport sink   (input valid, write_address, write_data, outside, run_end,
                    output ready);
endinterface

[hw/rtl/padded_glyph_blit.sv]
// ----------------------------------------------------------------------------
// padded_glyph_blit
// Glyph blitter into a 2D atlas store with an optional one-pixel border.
// ----------------------------------------------------------------------------
// Glyph pixels arrive in row order on i_pix; each one produces its own atlas
// write request first, then the border writes it owns (left/right/top/bottom
// edges and corners), in the order up-left, up, up-right, left, right,
// down-left, down, down-right; run_end marks the last request of a pixel.
// Throughput is one write request per clock while o_wr.ready is high; an
// interior pixel makes one request, an edge pixel two to four (up to six in
// a glyph one pixel wide or high) and a one-pixel glyph up to nine. The
// single-write sequencer in the back end sets that rate. Pixels enter a
// two-stage front end (position and border classification, then the slot
// base multiply) and wait in a four-entry queue, so the input takes pixels
// while results stall until the queue and both stages fill. A pixel passes
// stage A, stage B, the queue, r_job and the output register in turn.
// Border positions outside the atlas come out with outside set and zero
// address and data. Write the configuration registers only while idle.
// ----------------------------------------------------------------------------
module padded_glyph_blit import pgb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pgb_in_if.sink                i_pix,
    pgb_out_if.source             o_wr
);

    // configuration registers
    logic [AW_W-1:0]   r_atlas_width;
    logic [BPP_W-1:0]  r_bpp;
    logic [MODE_W-1:0] r_mode;

    t_cfg cfg;
    logic push, full, pop, empty;
    t_job job_in, job_out;

    // clamp the pixel size, derive the row stride and decode the border mode;
    // an unknown mode acts as no border
    always_comb begin
        cfg.atlas_width = r_atlas_width;
        cfg.bpp         = eff_bpp(r_bpp);
        cfg.stride      = STRIDE_W'(r_atlas_width) * STRIDE_W'(cfg.bpp);
        cfg.pad         = (r_mode == PAD_ZERO) || (r_mode == PAD_DILATE);
        cfg.dilate      = r_mode == PAD_DILATE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_width <= AW_W'(512);
            r_bpp         <= BPP_W'(1);
            r_mode        <= PAD_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ATLAS_WIDTH:  r_atlas_width <= i_cfg_data[AW_W-1:0];
                REG_BYTES_PER_PX: r_bpp         <= i_cfg_data[BPP_W-1:0];
                REG_PADDING_MODE: r_mode        <= i_cfg_data[MODE_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // front: accept, count position, classify border work
    pgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    // hold classified pixels between the two halves
    pgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // back: issue write requests one per cycle while o_wr is not stalled
    pgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_wr    (o_wr)
    );

endmodule

[hw/rtl/pgb_front.sv]
// ----------------------------------------------------------------------------
// pgb_front
// Accept pixel requests, track the glyph position and classify border work.
// Two stages: position/classify, then slot base multiply and own address.
// ----------------------------------------------------------------------------
module pgb_front import pgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    pgb_in_if.sink      i_pix,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    // position state
    logic [CNT_W-1:0]    r_col, n_col;
    logic [CNT_W-1:0]    r_row, n_row;
    logic [COLOFF_W-1:0] r_col_off, n_col_off;
    logic [ADDR_W-1:0]   r_row_off, n_row_off;
    logic [ADDR_W-1:0]   r_glyph_base;

    // stage A
    logic                r_a_vld;
    logic                r_a_start;
    logic [PROD_W-1:0]   r_a_p1;
    logic [ADDR_W-1:0]   r_a_off;
    logic [DATA_W-1:0]   r_a_pix;
    logic [NPOS-1:0]     r_a_need;
    logic [NPOS-1:0]     r_a_out;
    logic                r_a_dil;

    // stage B
    logic                r_b_vld;
    t_job                r_b_job;

    logic                a_free, b_free, in_acc;
    logic [CNT_W-1:0]    cur_col, cur_row;
    logic [COLOFF_W-1:0] cur_col_off;
    logic [ADDR_W-1:0]   cur_row_off;
    logic [SIZE_W-1:0]   w_eff, h_eff;
    logic                wrap, left, right, top, bottom;
    logic [SIZE_W-1:0]   xs, ys;
    logic                okx_m, okx_0, okx_p, oky_m, oky_0, oky_p;
    logic [NPOS-1:0]     need, outb;
    logic [ADDR_W-1:0]   base_prod, base_sel;

    assign b_free      = !r_b_vld || !i_full;
    assign a_free      = !r_a_vld || b_free;
    assign i_pix.ready = a_free;
    assign in_acc      = i_pix.valid && a_free;
    assign o_push      = r_b_vld && !i_full;
    assign o_job       = r_b_job;

    always_comb begin
        cur_col     = i_pix.glyph_start ? '0 : r_col;
        cur_row     = i_pix.glyph_start ? '0 : r_row;
        cur_col_off = i_pix.glyph_start ? '0 : r_col_off;
        cur_row_off = i_pix.glyph_start ? '0 : r_row_off;
        w_eff       = eff_size(i_pix.slot_width);
        h_eff       = eff_size(i_pix.slot_height);

        wrap   = ({1'b0, cur_col} + SIZE_W'(1)) >= w_eff;
        left   = cur_col == '0;
        top    = cur_row == '0;
        right  = {1'b0, cur_col} == (w_eff - SIZE_W'(1));
        bottom = {1'b0, cur_row} == (h_eff - SIZE_W'(1));

        // border position tests against the atlas bounds
        xs    = SIZE_W'(i_pix.slot_x) + SIZE_W'(cur_col);
        ys    = SIZE_W'(i_pix.slot_y) + SIZE_W'(cur_row);
        okx_m = (xs != '0) && ((xs - SIZE_W'(1)) < i_cfg.atlas_width);
        okx_0 = xs < i_cfg.atlas_width;
        okx_p = ({1'b0, xs} + (SIZE_W+1)'(1)) < {1'b0, i_cfg.atlas_width};
        oky_m = (ys != '0) && (SIDE_CMP_W'(ys - SIZE_W'(1)) < SIDE_CMP_W'(MAX_ATLAS_SIDE));
        oky_0 = SIDE_CMP_W'(ys) < SIDE_CMP_W'(MAX_ATLAS_SIDE);
        oky_p = (SIDE_CMP_W'(ys) + SIDE_CMP_W'(1)) < SIDE_CMP_W'(MAX_ATLAS_SIDE);

        need         = '0;
        need[POS_UL] = top && left;
        need[POS_U]  = top;
        need[POS_UR] = top && right;
        need[POS_L]  = left;
        need[POS_R]  = right;
        need[POS_DL] = bottom && left;
        need[POS_D]  = bottom;
        need[POS_DR] = bottom && right;
        if (!i_cfg.pad) need = '0;

        outb         = '0;
        outb[POS_UL] = !(okx_m && oky_m);
        outb[POS_U]  = !(okx_0 && oky_m);
        outb[POS_UR] = !(okx_p && oky_m);
        outb[POS_L]  = !(okx_m && oky_0);
        outb[POS_R]  = !(okx_p && oky_0);
        outb[POS_DL] = !(okx_m && oky_p);
        outb[POS_D]  = !(okx_0 && oky_p);
        outb[POS_DR] = !(okx_p && oky_p);

        if (wrap) begin
            n_col     = '0;
            n_col_off = '0;
            n_row     = cur_row + CNT_W'(1);
            n_row_off = cur_row_off + ADDR_W'(i_cfg.stride);
        end else begin
            n_col     = cur_col + CNT_W'(1);
            n_col_off = cur_col_off + COLOFF_W'(i_cfg.bpp);
            n_row     = cur_row;
            n_row_off = cur_row_off;
        end
    end

    // slot base: (y * atlas_width + x) * bpp, second multiply in stage B
    always_comb begin
        base_prod = ADDR_W'((PROD_W + BPP_W)'(r_a_p1) * (PROD_W + BPP_W)'(i_cfg.bpp));
        base_sel  = r_a_start ? base_prod : r_glyph_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_col_off    <= '0;
            r_row_off    <= '0;
            r_glyph_base <= '0;
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_col_off <= n_col_off;
                r_row_off <= n_row_off;
            end
            if (a_free) r_a_vld <= in_acc;
            if (b_free) r_b_vld <= r_a_vld;
            if (b_free && r_a_vld && r_a_start) r_glyph_base <= base_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_start <= i_pix.glyph_start;
            r_a_p1    <= PROD_W'(i_pix.slot_y) * PROD_W'(i_cfg.atlas_width)
                         + PROD_W'(i_pix.slot_x);
            r_a_off   <= cur_row_off + ADDR_W'(cur_col_off);
            r_a_pix   <= i_pix.pixel_value & pix_mask(i_cfg.bpp);
            r_a_need  <= need;
            r_a_out   <= outb;
            r_a_dil   <= i_cfg.dilate;
        end
        if (b_free && r_a_vld) begin
            r_b_job.own     <= base_sel + r_a_off;
            r_b_job.pix     <= r_a_pix;
            r_b_job.need    <= r_a_need;
            r_b_job.outside <= r_a_out;
            r_b_job.dilate  <= r_a_dil;
        end
    end

endmodule

[hw/rtl/pgb_queue.sv]
// ----------------------------------------------------------------------------
// pgb_queue
// Short job queue between the classifying front and the write sequencer.
// ----------------------------------------------------------------------------
module pgb_queue import pgb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + Q_PTR_W'(1);
            if (do_pop)  r_rd <= r_rd + Q_PTR_W'(1);
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

[hw/rtl/pgb_back.sv]
// ----------------------------------------------------------------------------
// pgb_back
// Write sequencer: one atlas write request per cycle unless o_wr stalls;
// own pixel first, then pending border positions in order, into a register.
// ----------------------------------------------------------------------------
module pgb_back import pgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    pgb_out_if.source   o_wr
);

    logic              r_act;
    logic              r_own_done;
    logic [NPOS-1:0]   r_need;
    t_job              r_job;

    logic              r_ovld;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_outside;
    logic              r_run_end;

    logic              adv_out, emit, last;
    logic [PIDX_W-1:0] pos;
    logic [NPOS-1:0]   rest;
    logic [ADDR_W-1:0] dy_term, dx_term;
    logic [ADDR_W-1:0] e_addr;
    logic [DATA_W-1:0] e_data;
    logic              e_outside;

    assign adv_out = !r_ovld || o_wr.ready;
    assign emit    = r_act && adv_out;
    assign o_pop   = !i_empty && (!r_act || (emit && last));

    assign o_wr.valid         = r_ovld;
    assign o_wr.write_address = r_addr;
    assign o_wr.write_data    = r_data;
    assign o_wr.outside       = r_outside;
    assign o_wr.run_end       = r_run_end;

    always_comb begin
        pos  = lowest_pos(r_need);
        rest = r_need & ~(NPOS'(1) << pos);

        case (pos) inside
            POS_UL, POS_U, POS_UR: dy_term = ADDR_W'(0) - ADDR_W'(i_cfg.stride);
            POS_DL, POS_D, POS_DR: dy_term = ADDR_W'(i_cfg.stride);
            default:               dy_term = '0;
        endcase
        case (pos) inside
            POS_UL, POS_L, POS_DL: dx_term = ADDR_W'(0) - ADDR_W'(i_cfg.bpp);
            POS_UR, POS_R, POS_DR: dx_term = ADDR_W'(i_cfg.bpp);
            default:               dx_term = '0;
        endcase

        if (!r_own_done) begin
            last      = r_need == '0;
            e_addr    = r_job.own;
            e_data    = r_job.pix;
            e_outside = 1'b0;
        end else begin
            last = rest == '0;
            if (r_job.outside[pos]) begin
                e_addr    = '0;
                e_data    = '0;
                e_outside = 1'b1;
            end else begin
                e_addr    = r_job.own + dy_term + dx_term;
                e_data    = r_job.dilate ? r_job.pix : '0;
                e_outside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_own_done <= 1'b0;
            r_need     <= '0;
            r_ovld     <= 1'b0;
        end else begin
            if (adv_out) r_ovld <= emit;
            if (o_pop) begin
                r_act      <= 1'b1;
                r_own_done <= 1'b0;
                r_need     <= i_job.need;
            end else if (emit) begin
                if (last) r_act <= 1'b0;
                if (r_own_done) r_need <= rest;
                r_own_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (emit) begin
            r_addr    <= e_addr;
            r_data    <= e_data;
            r_outside <= e_outside;
            r_run_end <= last;
        end
    end

endmodule

[hw/rtl/pgb_checker.sv]
// ----------------------------------------------------------------------------
// pgb_checker
// Port-level checks on the padded glyph blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "padded_glyph_blit_macros.svh"

module pgb_checker import pgb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ADDR_W-1:0] i_out_addr,
    input logic [DATA_W-1:0] i_out_data,
    input logic              i_out_outside,
    input logic              i_out_run_end
);

    logic [3:0] r_res;   // requests since the last run_end
    logic [3:0] r_pend;  // pixels taken whose run has not ended
    logic       in_acc, out_acc, run_done, hold_req, zero_payload;
    logic [ADDR_W+DATA_W+1:0] out_word;

    assign in_acc       = i_in_valid && i_in_ready;
    assign out_acc      = i_out_valid && i_out_ready;
    assign run_done     = out_acc && i_out_run_end;
    assign hold_req     = i_out_valid && !i_out_ready;
    assign zero_payload = (i_out_addr == '0) && (i_out_data == '0);
    assign out_word     = {i_out_addr, i_out_data, i_out_outside, i_out_run_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res  <= '0;
            r_pend <= '0;
        end else begin
            if (out_acc) r_res <= i_out_run_end ? 4'd0 : r_res + 4'd1;
            r_pend <= r_pend + 4'(in_acc) - 4'(run_done);
        end
    end

    `PGB_ASSERT_IMP(a_outside_zero, i_out_valid && i_out_outside, zero_payload)
    `PGB_ASSERT_NXT(a_stall_hold, hold_req, i_out_valid && $stable(out_word))
    `PGB_ASSERT_IMP(a_run_max_nine, out_acc && r_res == 4'd8, i_out_run_end)
    `PGB_ASSERT_IMP(a_no_orphan, i_out_valid, r_pend != '0)

endmodule

bind padded_glyph_blit pgb_checker u_pgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_wr.valid),
    .i_out_ready   (o_wr.ready),
    .i_out_addr    (o_wr.write_address),
    .i_out_data    (o_wr.write_data),
    .i_out_outside (o_wr.outside),
    .i_out_run_end (o_wr.run_end)
);
